// ----- src/shl2g_pkg.sv -----
// Shared constants, types and helpers for the strip hit local-to-global converter.
// No dependencies; used by strip_hit_local_to_global by scoped names.
`default_nettype none

package shl2g_pkg;

  // Store geometry
  localparam int LAYER_COUNT  = 16;
  localparam int LADDER_COUNT = 16;
  localparam int MODULE_COUNT = 32;
  localparam int NUM_COEF     = 9;
  localparam int MEM_DEPTH    = LAYER_COUNT * LADDER_COUNT * MODULE_COUNT;
  localparam int ADDR_W       = $clog2(MEM_DEPTH);

  // Coefficient groups: centre, strip step, segment step (x, y, z each)
  localparam int CENTRE_BASE = 0;
  localparam int STRIP_BASE  = 3;
  localparam int SEG_BASE    = 6;
  localparam int NUM_AXES    = 3;

  // Field widths
  localparam int LAYER_W  = 4;
  localparam int LADDER_W = 4;
  localparam int MODIDX_W = 5;
  localparam int SEGNUM_W = 5;
  localparam int STRIP_W  = 11;
  localparam int SEL_W    = 4;
  localparam int COEF_W   = 32;

  // Input tdata layout, lowest field first
  localparam int LAYER_LSB  = 0;
  localparam int LADDER_LSB = LAYER_LSB + LAYER_W;
  localparam int MODIDX_LSB = LADDER_LSB + LADDER_W;
  localparam int SEGNUM_LSB = MODIDX_LSB + MODIDX_W;
  localparam int STRIP_LSB  = SEGNUM_LSB + SEGNUM_W;
  localparam int SEL_LSB    = STRIP_LSB + STRIP_W;
  localparam int VALUE_LSB  = SEL_LSB + SEL_W;
  localparam int IN_BITS    = VALUE_LSB + COEF_W;
  localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W = NUM_AXES * COEF_W;

  // Twice-relative offsets (centres are half-integers, kept doubled)
  localparam int PS_STRIP_CENTRE2 = 959;   // 479.5 * 2
  localparam int SS_STRIP_CENTRE2 = 1015;  // 507.5 * 2
  localparam int PS_SEG_CENTRE2   = 31;    // 15.5 * 2
  localparam int SS_SEG_CENTRE2   = 1;     // 0.5 * 2
  localparam int PS_LAYER_LIMIT   = 8;
  localparam int BARREL_LIMIT     = 3;

  // Datapath widths
  localparam int RS_W    = STRIP_W + 1;           // twice relative strip
  localparam int SG_W    = SEGNUM_W + 2;          // twice relative segment
  localparam int PRODS_W = COEF_W + RS_W;
  localparam int PRODG_W = COEF_W + SG_W;
  localparam int SUM_W   = PRODS_W + 2;

  typedef enum logic {
    ACT_CONVERT = 1'b0,
    ACT_WRITE   = 1'b1
  } action_e;

  typedef logic signed [COEF_W-1:0]  coef_t;
  typedef logic signed [RS_W-1:0]    rs_t;
  typedef logic signed [SG_W-1:0]    sg_t;
  typedef logic signed [PRODS_W-1:0] prods_t;
  typedef logic signed [PRODG_W-1:0] prodg_t;
  typedef logic signed [SUM_W-1:0]   sum_t;
  typedef logic [ADDR_W-1:0]         addr_t;

  function automatic logic index_ok(input logic [LAYER_W-1:0]  layer,
                                    input logic [LADDER_W-1:0] ladder,
                                    input logic [MODIDX_W-1:0] mod_idx);
    return (int'(layer) < LAYER_COUNT) && (int'(ladder) < LADDER_COUNT) &&
           (int'(mod_idx) < MODULE_COUNT);
  endfunction

  function automatic addr_t module_addr(input logic [LAYER_W-1:0]  layer,
                                        input logic [LADDER_W-1:0] ladder,
                                        input logic [MODIDX_W-1:0] mod_idx);
    return ADDR_W'((int'(layer) * LADDER_COUNT + int'(ladder)) * MODULE_COUNT
                   + int'(mod_idx));
  endfunction

endpackage

`default_nettype wire

// ----- src/strip_hit_local_to_global.sv -----
// Top level of the strip hit local-to-global converter: coefficient store and
// four-stage conversion pipeline. Depends on shl2g_pkg.
`default_nettype none

// Converts tracker hits (layer, ladder, module, segment, half-strip) to global
// X, Y, Z in signed Q11.20 cm. Each module holds nine coefficients: centre,
// strip step and segment step vectors. An input item with tuser = 1 writes one
// coefficient (coef_select picks it) and gives no result; tuser = 0 converts a
// hit and gives exactly one result. Results leave one per clock sustained while
// m_axis_tready stays high; the pipeline is the registered coefficient read,
// the multiply stage, the sum stage and the saturating output register. Each
// stage advances on its own, so bubbles close up and new items are taken while
// a result waits at the output. A convert that follows a write in the next
// cycle already sees the new coefficient. Coefficients are held in nine
// 8192-word memories, one per coefficient, so all nine are read together;
// they power up undefined and must be written before use. The flip register
// (cfg channel) negates the endcap strip term in X and Y and is only to be
// written while the block is idle.
module strip_hit_local_to_global (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // configuration: bit 0 = flip_endcap_strip
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic                               cfg_data_i,
  // input items
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // tdata: layer_index, ladder_index, module_index, segment_number,
  //        strip_halves, coef_select, coefficient word, zero fill
  input  wire logic [shl2g_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // tuser: action
  input  wire logic                               s_axis_tuser,
  // result items
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // tdata: global_x, global_y, global_z
  output logic [shl2g_pkg::OUT_DATA_W-1:0]        m_axis_tdata
);

  localparam int NA = shl2g_pkg::NUM_AXES;

  // ---------------------------------------------------------------- config
  logic flip_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flip_q <= 1'b0;
    end else if (cfg_valid_i) begin
      flip_q <= cfg_data_i;
    end
  end

  // ---------------------------------------------------------------- handshake
  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;
  logic in_acc;

  // a stage takes new data when it is empty or its content moves on
  assign rdy4          = !v4_q || m_axis_tready;
  assign rdy3          = !v3_q || rdy4;
  assign rdy2          = !v2_q || rdy3;
  assign rdy1          = !v1_q || rdy2;
  assign s_axis_tready = rdy1;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // ---------------------------------------------------------------- field unpack
  logic [shl2g_pkg::LAYER_W-1:0]  layer_in;
  logic [shl2g_pkg::LADDER_W-1:0] ladder_in;
  logic [shl2g_pkg::MODIDX_W-1:0] modidx_in;
  logic [shl2g_pkg::SEGNUM_W-1:0] segnum_in;
  logic [shl2g_pkg::STRIP_W-1:0]  strip_in;
  logic [shl2g_pkg::SEL_W-1:0]    sel_in;
  shl2g_pkg::coef_t               value_in;
  shl2g_pkg::action_e             action_in;
  shl2g_pkg::addr_t               addr_in;
  logic                           ok_in;
  logic                           wr_en;
  logic                           is_ps;
  logic                           is_barrel;
  shl2g_pkg::rs_t                 rs2_d;
  shl2g_pkg::sg_t                 sg2_d;

  assign layer_in  = s_axis_tdata[shl2g_pkg::LAYER_LSB  +: shl2g_pkg::LAYER_W];
  assign ladder_in = s_axis_tdata[shl2g_pkg::LADDER_LSB +: shl2g_pkg::LADDER_W];
  assign modidx_in = s_axis_tdata[shl2g_pkg::MODIDX_LSB +: shl2g_pkg::MODIDX_W];
  assign segnum_in = s_axis_tdata[shl2g_pkg::SEGNUM_LSB +: shl2g_pkg::SEGNUM_W];
  assign strip_in  = s_axis_tdata[shl2g_pkg::STRIP_LSB  +: shl2g_pkg::STRIP_W];
  assign sel_in    = s_axis_tdata[shl2g_pkg::SEL_LSB    +: shl2g_pkg::SEL_W];
  assign value_in  = s_axis_tdata[shl2g_pkg::VALUE_LSB  +: shl2g_pkg::COEF_W];
  assign action_in = shl2g_pkg::action_e'(s_axis_tuser);

  assign addr_in = shl2g_pkg::module_addr(layer_in, ladder_in, modidx_in);
  assign ok_in   = shl2g_pkg::index_ok(layer_in, ladder_in, modidx_in);
  assign wr_en   = in_acc && (action_in == shl2g_pkg::ACT_WRITE) && ok_in &&
                   (int'(sel_in) < shl2g_pkg::NUM_COEF);

  always_comb begin
    is_ps     = int'(layer_in) < shl2g_pkg::PS_LAYER_LIMIT;
    is_barrel = int'(layer_in[2:0]) < shl2g_pkg::BARREL_LIMIT;
    if (is_ps) begin
      rs2_d = $signed({1'b0, strip_in})
              - $signed(shl2g_pkg::RS_W'(shl2g_pkg::PS_STRIP_CENTRE2));
      sg2_d = $signed({1'b0, segnum_in, 1'b0})
              - $signed(shl2g_pkg::SG_W'(shl2g_pkg::PS_SEG_CENTRE2));
    end else begin
      rs2_d = $signed({1'b0, strip_in})
              - $signed(shl2g_pkg::RS_W'(shl2g_pkg::SS_STRIP_CENTRE2));
      sg2_d = $signed({1'b0, segnum_in, 1'b0})
              - $signed(shl2g_pkg::SG_W'(shl2g_pkg::SS_SEG_CENTRE2));
    end
  end

  // ---------------------------------------------------------------- stage 1: store read
  shl2g_pkg::coef_t rd_q [shl2g_pkg::NUM_COEF];
  shl2g_pkg::rs_t   rs2_1_q;
  shl2g_pkg::sg_t   sg2_1_q;
  logic             neg1_q;
  logic             ok1_q;

  for (genvar g = 0; g < shl2g_pkg::NUM_COEF; g++) begin : g_store
    shl2g_pkg::coef_t mem [shl2g_pkg::MEM_DEPTH];

    always_ff @(posedge clk_i) begin
      if (wr_en && (int'(sel_in) == g)) begin
        mem[addr_in] <= value_in;
      end
      if (rdy1) begin
        rd_q[g] <= mem[addr_in];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      rs2_1_q <= rs2_d;
      sg2_1_q <= sg2_d;
      neg1_q  <= !is_barrel && flip_q;
      ok1_q   <= ok_in;
    end
  end

  // ---------------------------------------------------------------- stage 2: products
  shl2g_pkg::coef_t  coef [shl2g_pkg::NUM_COEF];
  shl2g_pkg::prods_t prod_s_q [NA];
  shl2g_pkg::prodg_t prod_g_q [NA];
  shl2g_pkg::coef_t  ctr2_q   [NA];
  logic              neg2_q;

  always_comb begin
    for (int k = 0; k < shl2g_pkg::NUM_COEF; k++) begin
      coef[k] = ok1_q ? rd_q[k] : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      for (int a = 0; a < NA; a++) begin
        prod_s_q[a] <= shl2g_pkg::PRODS_W'(coef[shl2g_pkg::STRIP_BASE + a])
                       * shl2g_pkg::PRODS_W'(rs2_1_q);
        prod_g_q[a] <= shl2g_pkg::PRODG_W'(coef[shl2g_pkg::SEG_BASE + a])
                       * shl2g_pkg::PRODG_W'(sg2_1_q);
        ctr2_q[a]   <= coef[shl2g_pkg::CENTRE_BASE + a];
      end
      neg2_q <= neg1_q;
    end
  end

  // ---------------------------------------------------------------- stage 3: halve and sum
  shl2g_pkg::sum_t term_s [NA];
  shl2g_pkg::sum_t term_g [NA];
  shl2g_pkg::sum_t sum3_q [NA];

  always_comb begin
    for (int a = 0; a < NA; a++) begin
      // arithmetic shift gives the floor of the halved product
      term_s[a] = shl2g_pkg::SUM_W'(prod_s_q[a] >>> 1);
      term_g[a] = shl2g_pkg::SUM_W'(prod_g_q[a] >>> 1);
      if (neg2_q && (a < 2)) begin
        term_s[a] = -term_s[a];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      for (int a = 0; a < NA; a++) begin
        sum3_q[a] <= shl2g_pkg::SUM_W'(ctr2_q[a]) + term_s[a] + term_g[a];
      end
    end
  end

  // ---------------------------------------------------------------- stage 4: saturate, output
  localparam shl2g_pkg::sum_t SAT_MAX = shl2g_pkg::SUM_W'(2147483647);
  localparam shl2g_pkg::sum_t SAT_MIN = -SAT_MAX - shl2g_pkg::SUM_W'(1);

  shl2g_pkg::coef_t out_q [NA];

  always_ff @(posedge clk_i) begin
    if (rdy4) begin
      for (int a = 0; a < NA; a++) begin
        if (sum3_q[a] > SAT_MAX) begin
          out_q[a] <= shl2g_pkg::coef_t'(SAT_MAX);
        end else if (sum3_q[a] < SAT_MIN) begin
          out_q[a] <= shl2g_pkg::coef_t'(SAT_MIN);
        end else begin
          out_q[a] <= shl2g_pkg::coef_t'(sum3_q[a]);
        end
      end
    end
  end

  always_comb begin
    for (int a = 0; a < NA; a++) begin
      m_axis_tdata[a*shl2g_pkg::COEF_W +: shl2g_pkg::COEF_W] = out_q[a];
    end
  end
  assign m_axis_tvalid = v4_q;

  // ---------------------------------------------------------------- valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= in_acc && (action_in == shl2g_pkg::ACT_CONVERT);
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
      if (rdy4) begin
        v4_q <= v3_q;
      end
    end
  end

  // ---------------------------------------------------------------- assertions
  // a coefficient write never puts an item into the pipeline
  a_write_no_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (action_in == shl2g_pkg::ACT_WRITE) |=> !v1_q)
    else $error("write item entered the conversion pipeline");

  // with the output register empty the whole pipe can move
  a_ready_when_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output register");

  // an item in stage 1 that may move reaches stage 2 next cycle
  a_stage_advance : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q && rdy2 |=> v2_q)
    else $error("item lost between read and multiply stages");

  // an X sum above range leaves as the positive limit
  a_sat_high : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q && rdy4 && (sum3_q[0] > SAT_MAX) |=> (out_q[0] == shl2g_pkg::coef_t'(SAT_MAX)))
    else $error("X not saturated to positive limit");

endmodule

`default_nettype wire
